@@ hw/rtl/fifo_page_replacement_top_assert.svh @@
// assertion macros for the fifo page replacement block
// all checks are clocked on clk and disabled while rst_n is low
`ifndef FIFO_PAGE_REPLACEMENT_TOP_ASSERT_SVH
`define FIFO_PAGE_REPLACEMENT_TOP_ASSERT_SVH

// same-cycle implication
`define FPR_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define FPR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ hw/rtl/fpr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpr_pkg
// shared types and constants of the fifo page replacement block
// ----------------------------------------------------------------------------
package fpr_pkg;

    localparam int PAGE_W          = 8;
    localparam int CFG_W           = 7;
    localparam int CNT_W           = 32;
    localparam int OUT_TDATA_W     = 80;
    localparam int PAGE_COUNT_DEF  = 256;
    localparam int FRAME_DEPTH_DEF = 64;

    localparam logic [CFG_W-1:0] FRAME_COUNT_RESET = 7'd4;

    // per-cell control from the top level
    typedef struct packed {
        logic shift;
        logic load;
    } cell_ctrl_t;

    // presence map update enables
    typedef struct packed {
        logic clr_en;
        logic set_en;
    } map_upd_t;

endpackage
`default_nettype wire

@@ hw/rtl/fifo_page_replacement_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fifo_page_replacement_top
// fifo page replacement over a chain of frame cells and a presence map
// ----------------------------------------------------------------------------
// usage
//   s_axis carries one page reference per word. m_axis returns one result
//   word per reference: hit flag, eviction flag, victim page and the two
//   saturating totals. cfg writes the frame count; the user must write it
//   only while idle, the block does not enforce it. a reference is looked
//   up in the presence map and the chain of frame cells in the cycle it is
//   accepted; its result is registered. throughput is one reference per
//   cycle unless the receiver stalls, set by the combinational map lookup
//   and the one-step shift of the cells. when the receiver stalls, the
//   output register holds its word and s_axis_tready drops until it is
//   taken; a new word is taken in the same cycle that the held one leaves.
//   reset clears the presence map, the fill count, the totals and the
//   output valid, and loads a frame count of 4. no clearing pass is
//   needed, the block takes words right after reset.
// ----------------------------------------------------------------------------
`include "fifo_page_replacement_top_assert.svh"
module fifo_page_replacement_top
    import fpr_pkg::*;
#(
    parameter int PAGE_COUNT  = PAGE_COUNT_DEF,
    parameter int FRAME_DEPTH = FRAME_DEPTH_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // [7:0] page_number
    input  wire logic [PAGE_W-1:0]      s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // [0] hit, [1] evicted_valid, [9:2] evicted_page,
    // [41:10] fault_total, [73:42] hit_total, [79:74] zero
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_W-1:0]       cfg_data
);

    localparam int AW = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;
    localparam int UW = $clog2(FRAME_DEPTH + 1);
    localparam int IW = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
    localparam int LW = (UW > CFG_W) ? UW : CFG_W;
    localparam int PADW = OUT_TDATA_W - (2 + PAGE_W + 2 * CNT_W);

    logic [CFG_W-1:0]  frame_count_reg;
    logic [UW-1:0]     used_reg;
    logic [UW-1:0]     used_next;
    logic [CNT_W-1:0]  fault_reg;
    logic [CNT_W-1:0]  fault_next;
    logic [CNT_W-1:0]  hits_reg;
    logic [CNT_W-1:0]  hits_next;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic              out_hit_reg;
    logic              out_ev_valid_reg;
    logic [PAGE_W-1:0] out_ev_page_reg;
    logic [CNT_W-1:0]  out_fault_reg;
    logic [CNT_W-1:0]  out_hits_reg;

    logic              accept;
    logic              in_range;
    logic              map_bit;
    logic              hit_c;
    logic              miss;
    logic              pop;
    logic [LW-1:0]     limit;
    logic [LW-1:0]     fc_ext;
    logic [LW-1:0]     depth_ext;
    logic [UW-1:0]     used_after;
    logic [AW-1:0]     wr_idx;
    logic [IW-1:0]     page_idx;
    logic [PAGE_W-1:0] victim;
    map_upd_t          map_upd;

    logic [PAGE_W-1:0] cell_data [FRAME_DEPTH];

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_count_reg <= FRAME_COUNT_RESET;
        end
        else if (cfg_valid)
        begin
            frame_count_reg <= cfg_data;
        end
    end

    // effective frame limit
    always_comb
    begin
        fc_ext    = LW'(frame_count_reg);
        depth_ext = LW'(FRAME_DEPTH);
        if (fc_ext == '0)
        begin
            limit = LW'(1);
        end
        else if (fc_ext > depth_ext)
        begin
            limit = depth_ext;
        end
        else
        begin
            limit = fc_ext;
        end
    end

    assign in_range   = 32'(s_axis_tdata) < 32'(PAGE_COUNT);
    assign page_idx   = IW'(s_axis_tdata);
    assign hit_c      = in_range && map_bit;
    assign miss       = in_range && !map_bit;
    assign pop        = miss && (LW'(used_reg) >= limit) && (used_reg != '0);
    assign used_after = used_reg - UW'(pop);
    assign wr_idx     = used_after[AW-1:0];
    assign victim     = cell_data[0];

    assign map_upd.clr_en = accept && pop;
    assign map_upd.set_en = accept && miss;

    fpr_map #(
        .PAGE_COUNT (PAGE_COUNT),
        .IW         (IW)
    ) u_map (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_idx  (page_idx),
        .rd_bit  (map_bit),
        .upd     (map_upd),
        .clr_idx (IW'(victim)),
        .set_idx (page_idx)
    );

    // chain of frame cells, cell 0 holds the oldest page
    for (genvar i = 0; i < FRAME_DEPTH; i++)
    begin : g_cell
        cell_ctrl_t        ctrl;
        logic [PAGE_W-1:0] neighbor;

        assign ctrl.shift = accept && pop;
        assign ctrl.load  = accept && miss && (wr_idx == AW'(i));

        if (i == FRAME_DEPTH - 1)
        begin : g_last
            assign neighbor = '0;
        end
        else
        begin : g_mid
            assign neighbor = cell_data[i + 1];
        end

        fpr_cell u_cell (
            .clk           (clk),
            .ctrl          (ctrl),
            .load_data     (s_axis_tdata),
            .neighbor_data (neighbor),
            .data          (cell_data[i])
        );
    end

    always_comb
    begin
        used_next  = used_reg;
        fault_next = fault_reg;
        hits_next  = hits_reg;
        if (accept)
        begin
            used_next = used_after + UW'(miss);
            if (miss && (fault_reg != '1))
            begin
                fault_next = fault_reg + CNT_W'(1);
            end
            if (hit_c && (hits_reg != '1))
            begin
                hits_next = hits_reg + CNT_W'(1);
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg      <= '0;
            fault_reg     <= '0;
            hits_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            used_reg      <= used_next;
            fault_reg     <= fault_next;
            hits_reg      <= hits_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_hit_reg      <= hit_c;
            out_ev_valid_reg <= pop;
            out_ev_page_reg  <= pop ? victim : '0;
            out_fault_reg    <= fault_next;
            out_hits_reg     <= hits_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{PADW{1'b0}}, out_hits_reg, out_fault_reg,
                            out_ev_page_reg, out_ev_valid_reg, out_hit_reg};

    `FPR_ASSERT_IMPL(a_used_bound, 1'b1, used_reg <= UW'(FRAME_DEPTH))
    `FPR_ASSERT_NEXT(a_hit_keeps_fill, accept && hit_c, $stable(used_reg))
    `FPR_ASSERT_NEXT(a_fault_count, accept && miss,
        (fault_reg == $past(fault_reg) + CNT_W'(1)) || ($past(fault_reg) == '1))
    `FPR_ASSERT_IMPL(a_stall_blocks_input, out_valid_reg && !m_axis_tready,
        !s_axis_tready)

endmodule
`default_nettype wire

@@ hw/rtl/fpr_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpr_cell
// one frame slot of the arrival-order chain, shifts toward the head on a pop
// ----------------------------------------------------------------------------
module fpr_cell
    import fpr_pkg::*;
(
    input  wire logic              clk,
    input  wire cell_ctrl_t        ctrl,
    input  wire logic [PAGE_W-1:0] load_data,
    input  wire logic [PAGE_W-1:0] neighbor_data,
    output logic      [PAGE_W-1:0] data
);

    logic [PAGE_W-1:0] data_reg;
    logic [PAGE_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.load)
        begin
            data_next = load_data;
        end
        else if (ctrl.shift)
        begin
            data_next = neighbor_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule
`default_nettype wire

@@ hw/rtl/fpr_map.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpr_map
// presence map, one flop per page, cleared at reset
// ----------------------------------------------------------------------------
module fpr_map
    import fpr_pkg::*;
#(
    parameter int PAGE_COUNT = PAGE_COUNT_DEF,
    parameter int IW         = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic [IW-1:0] rd_idx,
    output logic               rd_bit,
    input  wire map_upd_t      upd,
    input  wire logic [IW-1:0] clr_idx,
    input  wire logic [IW-1:0] set_idx
);

    logic [PAGE_COUNT-1:0] map_reg;
    logic [PAGE_COUNT-1:0] map_next;

    always_comb
    begin
        map_next = map_reg;
        if (upd.clr_en)
        begin
            map_next[clr_idx] = 1'b0;
        end
        if (upd.set_en)
        begin
            map_next[set_idx] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_reg <= '0;
        end
        else
        begin
            map_reg <= map_next;
        end
    end

    assign rd_bit = map_reg[rd_idx];

endmodule
`default_nettype wire

@@ tb/sv/page_reference_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_reference_checker
// watches the reference, result and frame count channels, tracks the
// resident pages in arrival order and checks every result word against
// the predicted hit, victim and totals, oldest prediction first
// ----------------------------------------------------------------------------
module page_reference_checker
    import fpr_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    input  logic                   s_axis_tready,
    input  logic [PAGE_W-1:0]      s_axis_tdata,
    input  logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_W-1:0]       cfg_data,
    output int                     error_count,
    output int                     outstanding
);

    localparam int RING_W = $clog2(FRAME_DEPTH_DEF);

    // first member in the top bits, so hit lands in bit 0
    typedef struct packed {
        logic [CNT_W-1:0]  hit_total;
        logic [CNT_W-1:0]  fault_total;
        logic [PAGE_W-1:0] evicted_page;
        logic              evicted_valid;
        logic              hit;
    } page_result_t;

    logic [PAGE_COUNT_DEF-1:0] resident;
    logic [PAGE_W-1:0]         frame_ring [FRAME_DEPTH_DEF];
    logic [RING_W-1:0]         oldest_slot;
    logic [RING_W-1:0]         next_slot;
    logic [CFG_W-1:0]          frames_used;
    logic [CFG_W-1:0]          frame_limit;
    logic [CNT_W-1:0]          fault_count;
    logic [CNT_W-1:0]          hit_count;
    page_result_t              predicted_results [$];
    page_result_t              want;
    page_result_t              got;

    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] value);
        return (&value) ? value : value + 1'b1;
    endfunction

    function automatic page_result_t resolve_reference(input logic [PAGE_W-1:0] page);
        page_result_t r;
        logic [PAGE_W-1:0] victim;
        int eff;
        r = '0;
        eff = (frame_limit == 0) ? 1 :
              (frame_limit > FRAME_DEPTH_DEF) ? FRAME_DEPTH_DEF : int'(frame_limit);
        if (resident[page]) begin
            r.hit = 1'b1;
            hit_count = bump(hit_count);
        end
        else begin
            fault_count = bump(fault_count);
            // evict one page when at or above the limit, so a lowered limit keeps the set size
            if (frames_used >= eff && frames_used > 0) begin
                victim = frame_ring[oldest_slot];
                oldest_slot = oldest_slot + 1'b1;
                frames_used = frames_used - 1'b1;
                resident[victim] = 1'b0;
                r.evicted_valid = 1'b1;
                r.evicted_page = victim;
            end
            if (frames_used < FRAME_DEPTH_DEF) begin
                frame_ring[next_slot] = page;
                next_slot = next_slot + 1'b1;
                frames_used = frames_used + 1'b1;
                resident[page] = 1'b1;
            end
        end
        r.fault_total = fault_count;
        r.hit_total = hit_count;
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [CNT_W-1:0] exp_v,
                                 input logic [CNT_W-1:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
            error_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            resident = '0;
            oldest_slot = '0;
            next_slot = '0;
            frames_used = '0;
            frame_limit = FRAME_COUNT_RESET;
            fault_count = '0;
            hit_count = '0;
            predicted_results.delete();
            outstanding = 0;
            error_count = 0;
        end
        else begin
            if (cfg_valid && cfg_ready)
                frame_limit = cfg_data;
            if (m_axis_tvalid && m_axis_tready) begin
                got = page_result_t'(m_axis_tdata[$bits(page_result_t)-1:0]);
                if (predicted_results.size() == 0) begin
                    $error("result word with no reference pending");
                    error_count++;
                end
                else begin
                    want = predicted_results.pop_front();
                    compare_field("hit", want.hit, got.hit);
                    compare_field("evicted_valid", want.evicted_valid, got.evicted_valid);
                    compare_field("evicted_page", want.evicted_page, got.evicted_page);
                    compare_field("fault_total", want.fault_total, got.fault_total);
                    compare_field("hit_total", want.hit_total, got.hit_total);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                predicted_results.insert(predicted_results.size(),
                                         resolve_reference(s_axis_tdata));
            outstanding = predicted_results.size();
        end
    end

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives page references and frame count writes into the fifo page
// replacement block under random source gaps and sink stalls, and takes
// the verdict from the checker running beside it
// ----------------------------------------------------------------------------
module testbench;
    import fpr_pkg::*;

    localparam int ITEMS_PER_PHASE = 157;
    localparam int HOLD_CYCLES     = 300;
    localparam int IDLE_LIMIT      = 2000;
    localparam int SETTLE_CYCLES   = 4;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [PAGE_W-1:0]      s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_W-1:0]       cfg_data = '0;
    int                     error_count;
    int                     outstanding;
    int                     idle_cycles = 0;
    bit                     tx_idle;
    bit                     rx_stall;
    bit                     hold_req;

    fifo_page_replacement_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    page_reference_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .error_count   (error_count),
        .outstanding   (outstanding)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int pick_gap(input bit enabled);
        int r;
        r = $urandom_range(0, 99);
        if (!enabled || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // sink side: short random stalls plus one long hold on request
    initial
    begin : sink
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left == 0 && stall_left == 0)
                stall_left = pick_gap(rx_stall);
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("testbench failed");
            $finish;
        end
    end

    task automatic send_page(input logic [PAGE_W-1:0] page);
        int gap;
        bit seen;
        gap = pick_gap(tx_idle);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= page;
        do
        begin
            @(negedge clk);
            seen = s_axis_tready;
            @(posedge clk);
        end
        while (!seen);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(negedge clk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_frame_count(input logic [CFG_W-1:0] value);
        bit seen;
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
        begin
            @(negedge clk);
            seen = cfg_ready;
            @(posedge clk);
        end
        while (!seen);
        cfg_valid <= 1'b0;
    endtask

    // references drawn mostly from a sliding working set of 1 to 2*eff+2 pages
    task automatic run_phase(input logic [CFG_W-1:0] frames, input int index);
        int eff;
        int base;
        int span;
        int page;
        write_frame_count(frames);
        tx_idle = (index % 4 != 0);
        rx_stall = (index % 4 != 0) && (index % 4 != 3);
        eff = (frames == 0) ? 1 : (frames > FRAME_DEPTH_DEF) ? FRAME_DEPTH_DEF : int'(frames);
        base = $urandom_range(0, 255);
        span = $urandom_range(1, 2 * eff + 2);
        for (int n = 0; n < ITEMS_PER_PHASE; n++)
        begin
            if (index == 2 && n == 40)
                hold_req = 1'b1;
            if (n % 40 == 39)
                base = base + $urandom_range(0, eff);
            if ($urandom_range(0, 9) == 0)
                page = $urandom_range(0, 255);
            else
                page = base + $urandom_range(0, span - 1);
            send_page(page[PAGE_W-1:0]);
        end
    endtask

    initial
    begin
        logic [CFG_W-1:0] phase_frames [12];
        phase_frames = '{7'd64, 7'd3, 7'd16, 7'd1, 7'd0, 7'd127,
                         7'd100, 7'd8, 7'd40, 7'd2, 7'd5, 7'd64};
        tx_idle = 1'b1;
        rx_stall = 1'b1;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset frame count of four: fill, hit, evict in arrival order
        send_page(8'h00);
        send_page(8'hff);
        send_page(8'h00);
        send_page(8'haa);
        send_page(8'h55);
        send_page(8'h01);
        send_page(8'h00);
        send_page(8'hff);
        send_page(8'h55);

        // limit lowered below the resident set
        write_frame_count(7'd1);
        send_page(8'h10);
        send_page(8'h10);
        send_page(8'h00);
        send_page(8'h20);

        // zero acts as one
        write_frame_count(7'd0);
        send_page(8'h30);
        send_page(8'h30);

        // above the frame store depth
        write_frame_count(7'd127);
        send_page(8'h40);
        send_page(8'h41);
        send_page(8'h40);

        foreach (phase_frames[i])
            run_phase(phase_frames[i], i);

        drain();
        if (error_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

@@ fifo_page_replacement_top.f @@
+incdir+hw/rtl
hw/rtl/fpr_pkg.sv
hw/rtl/fpr_cell.sv
hw/rtl/fpr_map.sv
hw/rtl/fifo_page_replacement_top.sv
tb/sv/page_reference_checker.sv
tb/sv/testbench.sv
